FILE: src/goertzel_bin_magnitude_core_macros.svh
// Assertion macros for the Goertzel bin magnitude core.
// Included by the core; no other dependencies.
`ifndef GOERTZEL_BIN_MAGNITUDE_CORE_MACROS_SVH
`define GOERTZEL_BIN_MAGNITUDE_CORE_MACROS_SVH

// same-cycle implication
`define GBM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/gbm_pkg.sv
// Shared widths and sequencer state type for the Goertzel bin magnitude core.
// No dependencies.
package gbm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEFF_W  = 16;
   localparam int FRAC_W   = 14;
   localparam int STATE_W  = 48;
   localparam int MAG_W    = 48;
   // holds coeff * s1 * s2 exactly
   localparam int ACC_W    = COEFF_W + 2 * STATE_W;
   // radicand bits, and sqrt remainder width
   localparam int RAD_W    = 2 * MAG_W;
   localparam int SQ_W     = MAG_W + 3;
   localparam int CNT_W    = $clog2(STATE_W);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SMPL_MUL,
      S_UPDATE,
      S_CS_MUL,
      S_Y_MUL,
      S_NEG,
      S_SQ2_MUL,
      S_SQ1_MUL,
      S_ABS,
      S_SQRT,
      S_DONE
   } state_type;

endpackage

FILE: src/goertzel_bin_magnitude_core.sv
// Channel  | Dir | Signals                          | Contents
// req      | in  | req_tvalid/tready/tdata/tlast     | tdata[15:0] sample, tlast = block end
// rsp      | out | rsp_tvalid/tready/tdata/tuser     | tdata[47:0] magnitude, tuser overflow
// csr      | in  | csr_wr_en/csr_wr_data             | coeff, Q2.14
//
// A sample goes through accept, 16 shift-add steps over coeff, and a state update.
// A block-end sample then adds three more 48-step multiplies, one
// 16-step multiply and a 48-step square root, all through the one 112-bit adder.
// Synchronous reset clears state and coeff; the result sits in an output register,
// so a new sample is accepted while it waits. A full output register holds the
// sequencer in its final state until rsp_tready frees it.
// Depends on gbm_pkg and goertzel_bin_magnitude_core_macros.svh.
`include "goertzel_bin_magnitude_core_macros.svh"

module goertzel_bin_magnitude_core
   import gbm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [COEFF_W-1:0]  csr_wr_data,  // coeff
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,    // [15:0] sample
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [MAG_W-1:0]    rsp_tdata,    // [47:0] magnitude
   output logic                rsp_tuser     // [0] overflow
);

   state_type          state_ff, state_in;
   logic [COEFF_W-1:0] coeff_ff;
   logic [STATE_W-1:0] recent_ff, recent_in;
   logic [STATE_W-1:0] older_ff, older_in;
   logic               sat_ff, sat_in;
   logic               last_ff, last_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   addend_ff, addend_in;
   logic [STATE_W-1:0] mplr_ff, mplr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               big_ff, big_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               ovf_ff, ovf_in;

   // shared adder
   logic [ACC_W-1:0]   alu_a, alu_b, alu_sum;
   logic               alu_cin;

   logic [ACC_W-1:0]   sample_sx, older_sx, recent_sx, snew_sx, acc_shr;
   logic [STATE_W-1:0] coeff_sx, sat_val, s_new;
   logic               fits;
   logic               in_mul, mul_end;
   logic [CNT_W-1:0]   mul_last;
   logic [ACC_W-1:0]   mul_b;
   logic               mul_cin;
   logic [SQ_W-1:0]    rem_new, trial;
   logic               sq_ge;

   assign alu_sum = alu_a + alu_b + {{(ACC_W-1){1'b0}}, alu_cin};

   assign sample_sx = {{(ACC_W-SAMPLE_W){req_tdata[SAMPLE_W-1]}}, req_tdata};
   assign older_sx  = {{(ACC_W-STATE_W){older_ff[STATE_W-1]}}, older_ff};
   assign recent_sx = {{(ACC_W-STATE_W){recent_ff[STATE_W-1]}}, recent_ff};
   assign coeff_sx  = {{(STATE_W-COEFF_W){coeff_ff[COEFF_W-1]}}, coeff_ff};

   // floor shift of the accumulated product, then clamp to state range
   assign acc_shr = $signed(acc_ff) >>> FRAC_W;
   assign fits    = (acc_shr[ACC_W-1:STATE_W-1] == '0) ||
                    (acc_shr[ACC_W-1:STATE_W-1] == '1);
   assign sat_val = acc_shr[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                     : {1'b0, {(STATE_W-1){1'b1}}};
   assign s_new   = fits ? acc_shr[STATE_W-1:0] : sat_val;
   assign snew_sx = {{(ACC_W-STATE_W){s_new[STATE_W-1]}}, s_new};

   // radix-2 signed multiply step; the multiplier sign bit has negative weight
   assign in_mul   = state_ff inside {S_SMPL_MUL, S_CS_MUL, S_Y_MUL, S_SQ2_MUL, S_SQ1_MUL};
   assign mul_last = (state_ff == S_SMPL_MUL || state_ff == S_CS_MUL) ?
                     CNT_W'(COEFF_W-1) : CNT_W'(STATE_W-1);
   assign mul_end  = (cnt_ff == mul_last);
   assign mul_b    = mplr_ff[0] ? (mul_end ? ~addend_ff : addend_ff) : '0;
   assign mul_cin  = mplr_ff[0] & mul_end;

   // digit-by-digit sqrt: remainder in addend_ff, root in mplr_ff, radicand in acc_ff
   assign rem_new = {addend_ff[SQ_W-3:0], acc_ff[RAD_W-1:RAD_W-2]};
   assign trial   = {1'b0, mplr_ff[MAG_W-1:0], 2'b01};
   assign sq_ge   = ~alu_sum[ACC_W-1];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mag_ff;
   assign rsp_tuser  = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else if (csr_wr_en) begin
         coeff_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         recent_ff    <= '0;
         older_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         recent_ff    <= recent_in;
         older_ff     <= older_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff   <= last_in;
      acc_ff    <= acc_in;
      addend_ff <= addend_in;
      mplr_ff   <= mplr_in;
      cnt_ff    <= cnt_in;
      big_ff    <= big_in;
      mag_ff    <= mag_in;
      ovf_ff    <= ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      recent_in    = recent_ff;
      older_in     = older_ff;
      sat_in       = sat_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      addend_in    = addend_ff;
      mplr_in      = mplr_ff;
      cnt_in       = cnt_ff;
      big_in       = big_ff;
      mag_in       = mag_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      alu_a        = '0;
      alu_b        = '0;
      alu_cin      = 1'b0;

      if (in_mul) begin
         alu_a     = acc_ff;
         alu_b     = mul_b;
         alu_cin   = mul_cin;
         acc_in    = alu_sum;
         addend_in = addend_ff << 1;
         mplr_in   = mplr_ff >> 1;
         cnt_in    = cnt_ff + CNT_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               // preload (x - s2) << FRAC_W so one floor shift finishes the update
               alu_a     = sample_sx;
               alu_b     = ~older_sx;
               alu_cin   = 1'b1;
               acc_in    = alu_sum << FRAC_W;
               addend_in = recent_sx;
               mplr_in   = coeff_sx;
               cnt_in    = '0;
               last_in   = req_tlast;
               state_in  = S_SMPL_MUL;
            end
         end
         S_SMPL_MUL: begin
            if (mul_end) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            recent_in = s_new;
            older_in  = recent_ff;
            sat_in    = sat_ff | ~fits;
            if (last_ff) begin
               acc_in    = '0;
               addend_in = snew_sx;
               mplr_in   = coeff_sx;
               cnt_in    = '0;
               state_in  = S_CS_MUL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CS_MUL: begin
            if (mul_end) begin
               // coeff * s1 becomes the multiplicand for the cross term
               addend_in = alu_sum;
               acc_in    = '0;
               mplr_in   = older_ff;
               cnt_in    = '0;
               state_in  = S_Y_MUL;
            end
         end
         S_Y_MUL: begin
            if (mul_end) begin
               state_in = S_NEG;
            end
         end
         S_NEG: begin
            alu_a     = ~acc_shr;
            alu_cin   = 1'b1;
            acc_in    = alu_sum;
            addend_in = older_sx;
            mplr_in   = older_ff;
            cnt_in    = '0;
            state_in  = S_SQ2_MUL;
         end
         S_SQ2_MUL: begin
            if (mul_end) begin
               addend_in = recent_sx;
               mplr_in   = recent_ff;
               cnt_in    = '0;
               state_in  = S_SQ1_MUL;
            end
         end
         S_SQ1_MUL: begin
            if (mul_end) begin
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            alu_a     = acc_ff[ACC_W-1] ? ~acc_ff : acc_ff;
            alu_cin   = acc_ff[ACC_W-1];
            acc_in    = alu_sum;
            // root would not fit the magnitude field
            big_in    = |alu_sum[ACC_W-1:RAD_W];
            addend_in = '0;
            mplr_in   = '0;
            cnt_in    = '0;
            state_in  = S_SQRT;
         end
         S_SQRT: begin
            alu_a     = {{(ACC_W-SQ_W){1'b0}}, rem_new};
            alu_b     = ~{{(ACC_W-SQ_W){1'b0}}, trial};
            alu_cin   = 1'b1;
            addend_in = {{(ACC_W-SQ_W){1'b0}}, (sq_ge ? alu_sum[SQ_W-1:0] : rem_new)};
            mplr_in   = {mplr_ff[STATE_W-2:0], sq_ge};
            acc_in    = acc_ff << 2;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAG_W-1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               mag_in       = big_ff ? '1 : mplr_ff[MAG_W-1:0];
               ovf_in       = sat_ff;
               recent_in    = '0;
               older_in     = '0;
               sat_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `GBM_ASSERT_NXT(a_done_loads_rsp, clock, reset, (state_ff == S_DONE && state_in == S_IDLE), rsp_tvalid, "block end left no result transaction")
   `GBM_ASSERT_NXT(a_done_clears, clock, reset, (state_ff == S_DONE && state_in == S_IDLE), (recent_ff == '0 && older_ff == '0 && !sat_ff), "state not cleared after result")
   `GBM_ASSERT_NXT(a_abs_nonneg, clock, reset, (state_ff == S_ABS), !acc_ff[ACC_W-1], "radicand negative after absolute value")
   `GBM_ASSERT_IMP(a_smpl_cnt, clock, reset, (state_ff == S_SMPL_MUL), (cnt_ff < CNT_W'(COEFF_W)), "sample multiply ran past coeff width")

endmodule
